[src/lrupr_pkg.sv]
// Shared widths, constants and result type for the LRU page-frame table.
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_W  = 20;
    localparam int SLOT_W  = 5;
    localparam int FAULT_W = 32;
    localparam int STAMP_W = 30;
    localparam int CFG_W   = 6;

    localparam logic [CFG_W-1:0]   CFG_RESET   = 6'd25;
    localparam logic [STAMP_W-1:0] TIME_MAX    = 30'h3FFF_FFFF;
    localparam logic [STAMP_W-1:0] TIME_RENORM = 30'h3FFF_FFFB;
    localparam logic [FAULT_W-1:0] FAULT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] frame_slot;
        logic [FAULT_W-1:0] fault_total;
    } result_t;

endpackage

`default_nettype wire

[src/lrupr_if.sv]
// Valid/ready channel interfaces for page references and lookup results.
`default_nettype none

interface lrupr_page_if;
    import lrupr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

interface lrupr_result_if;
    import lrupr_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic [FAULT_W-1:0] fault_total;

    modport source (output valid, output hit, output frame_slot, output fault_total,
                    input ready);
    modport sink (input valid, input hit, input frame_slot, input fault_total,
                  output ready);
endinterface

`default_nettype wire

[src/lrupr_engine.sv]
// Frame memory, scan sequencer, replacement choice and stamp renormalization.
`default_nettype none

module lrupr_engine #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use,
    lrupr_page_if.sink                    req,
    input  logic                          out_free,
    output logic                          result_load,
    output lrupr_pkg::result_t            result
);
    import lrupr_pkg::*;

    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENTRY_W = PAGE_W + STAMP_W;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN      = 7'b0000010,
        ST_UPDATE    = 7'b0000100,
        ST_MIN_START = 7'b0001000,
        ST_MIN_SCAN  = 7'b0010000,
        ST_SUB_START = 7'b0100000,
        ST_SUB       = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [ENTRY_W-1:0] mem [MAX_FRAMES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [PAGE_W-1:0]  page_reg;
    logic [STAMP_W-1:0] time_reg;
    logic [CNT_W-1:0]   filled_reg;
    logic [FAULT_W-1:0] fault_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [IDX_W-1:0]   oldest_idx_reg;
    logic [STAMP_W-1:0] oldest_stamp_reg;
    logic [STAMP_W-1:0] min_reg;

    logic [PAGE_W-1:0]  rd_page;
    logic [STAMP_W-1:0] rd_stamp;
    logic               match;
    logic               scan_last;
    logic               accept;
    logic [CNT_W-1:0]   cap;
    logic               room;
    logic [IDX_W-1:0]   upd_slot;
    logic [IDX_W+4:0]   slot_wide;
    logic [FAULT_W-1:0] fault_upd;
    logic [STAMP_W-1:0] time_inc;

    assign rd_page   = rd_data_reg[ENTRY_W-1 -: PAGE_W];
    assign rd_stamp  = rd_data_reg[STAMP_W-1:0];
    assign match     = (rd_page == page_reg);
    assign scan_last = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == filled_reg);
    assign accept    = req.valid && req.ready;
    assign time_inc  = (time_reg < TIME_MAX) ? time_reg + STAMP_W'(1) : time_reg;

    always_comb
    begin
        if (frames_in_use == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (CMP_W'(frames_in_use) > CMP_W'(MAX_FRAMES))
        begin
            cap = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            cap = CNT_W'(frames_in_use);
        end
    end

    assign room = (filled_reg < cap);

    always_comb
    begin
        if (hit_reg)
        begin
            upd_slot = slot_reg;
        end
        else if (room)
        begin
            upd_slot = filled_reg[IDX_W-1:0];
        end
        else
        begin
            upd_slot = oldest_idx_reg;
        end
    end

    assign fault_upd = (!hit_reg && fault_reg != FAULT_MAX) ? fault_reg + FAULT_W'(1)
                                                            : fault_reg;
    assign slot_wide = {5'b0, upd_slot};

    assign result.hit         = hit_reg;
    assign result.frame_slot  = slot_wide[SLOT_W-1:0];
    assign result.fault_total = fault_upd;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        rd_en       = 1'b0;
        rd_addr     = cmp_idx_reg + IDX_W'(1);
        wr_en       = 1'b0;
        wr_addr     = upd_slot;
        wr_data     = {page_reg, time_reg};
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_addr = '0;
                    if (filled_reg == '0)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (match || scan_last)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    wr_en       = 1'b1;
                    result_load = 1'b1;
                    state_next  = (time_reg >= TIME_RENORM) ? ST_MIN_START : ST_IDLE;
                end
            end
            ST_MIN_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_MIN_SCAN;
            end
            ST_MIN_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_SUB_START;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            ST_SUB_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                wr_en   = 1'b1;
                wr_addr = cmp_idx_reg;
                wr_data = {rd_page, rd_stamp - min_reg};
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            filled_reg  <= '0;
            fault_reg   <= '0;
            cmp_idx_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg) inside
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        time_reg    <= time_inc;
                        cmp_idx_reg <= '0;
                        hit_reg     <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    else
                    begin
                        cmp_idx_reg <= cmp_idx_reg + IDX_W'(1);
                    end
                end
                ST_UPDATE:
                begin
                    if (out_free)
                    begin
                        fault_reg <= fault_upd;
                        if (!hit_reg && room)
                        begin
                            filled_reg <= filled_reg + CNT_W'(1);
                        end
                    end
                end
                ST_MIN_START, ST_SUB_START:
                begin
                    cmp_idx_reg <= '0;
                end
                ST_MIN_SCAN:
                begin
                    cmp_idx_reg <= cmp_idx_reg + IDX_W'(1);
                end
                ST_SUB:
                begin
                    cmp_idx_reg <= cmp_idx_reg + IDX_W'(1);
                    if (scan_last)
                    begin
                        time_reg <= time_reg - min_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= req.page_number;
        end
        if (state_reg == ST_SCAN)
        begin
            if (match)
            begin
                slot_reg <= cmp_idx_reg;
            end
            else if (cmp_idx_reg == '0 || rd_stamp < oldest_stamp_reg)
            begin
                oldest_idx_reg   <= cmp_idx_reg;
                oldest_stamp_reg <= rd_stamp;
            end
        end
        if (state_reg == ST_MIN_SCAN)
        begin
            if (cmp_idx_reg == '0 || rd_stamp < min_reg)
            begin
                min_reg <= rd_stamp;
            end
        end
    end

endmodule

`default_nettype wire

[src/lrupr_out_stage.sv]
// Output register that holds one result until the receiver takes it.
`default_nettype none

module lrupr_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               result_load,
    input  lrupr_pkg::result_t result,
    output logic               out_free,
    lrupr_result_if.source     rsp
);
    import lrupr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign out_free        = !valid_reg || rsp.ready;
    assign rsp.valid       = valid_reg;
    assign rsp.hit         = data_reg.hit;
    assign rsp.frame_slot  = data_reg.frame_slot;
    assign rsp.fault_total = data_reg.fault_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

[src/lru_page_replacement_top.sv]
// Top level of the LRU page-frame table (counter method).
//
// req carries one page reference per transfer; rsp returns one result per
// reference: hit flag, frame index now holding the page, and the saturating
// fault count. cfg_we/cfg_wdata write frames_in_use (0 acts as 1, values above
// MAX_FRAMES act as MAX_FRAMES); write it only while the block is idle.
// Each reference is scanned against the frame memory one entry per cycle
// through its single read port, up to the first match or last filled frame;
// the write-back state then stores the frame and loads the result register,
// and only then is req ready again. The result shows the cycle after that write.
// When the clock stamp nears 2^30 the block makes one pass to find the
// smallest stamp and a second to subtract it from every filled frame.
// Reset empties the table and clears clock and fault count; frames_in_use
// returns to 25. The memory needs no clearing pass.
// A stalled receiver holds the result in the output register; the block takes
// the next reference meanwhile and waits in its write-back cycle until the
// output register frees.
`default_nettype none

module lru_page_replacement_top #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
    lrupr_page_if.sink                  req,
    lrupr_result_if.source              rsp
);
    import lrupr_pkg::*;

    logic [CFG_W-1:0] frames_in_use_reg;
    logic             result_load;
    logic             out_free;
    result_t          result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            frames_in_use_reg <= cfg_wdata;
        end
    end

    lrupr_engine #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .frames_in_use (frames_in_use_reg),
        .req           (req),
        .out_free      (out_free),
        .result_load   (result_load),
        .result        (result)
    );

    lrupr_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result      (result),
        .out_free    (out_free),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

[tb/lru_page_replacement_top_tb.sv]
// Self-checking testbench for the LRU page-frame table: directed and random page references.
module lru_page_replacement_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrupr_pkg::*;

    localparam int FRAMES      = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 80;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;

    lrupr_page_if   req_ch ();
    lrupr_result_if rsp_ch ();

    lru_page_replacement_top #(
        .MAX_FRAMES (FRAMES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [PAGE_W-1:0]  frame_page_q  [FRAMES];
    logic [STAMP_W-1:0] frame_stamp_q [FRAMES];
    int unsigned        frames_filled_q;
    logic [STAMP_W-1:0] time_now_q;
    logic [FAULT_W-1:0] fault_count_q;
    logic [CFG_W-1:0]   capacity_q;

    result_t predicted_lookups [$];

    int send_idle_pct;
    int recv_stall_pct;
    int holdoff_left;
    int references_sent;
    int results_checked;
    int hits_seen;
    int capacity_writes;
    int errors;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_lookups.size());
            $display("FAIL lru_page_replacement_top");
            $finish;
        end
    end

    function automatic result_t lookup_page(input logic [PAGE_W-1:0] page);
        result_t            res;
        int unsigned        n;
        int unsigned        limit;
        int unsigned        slot;
        int unsigned        oldest;
        bit                 found;
        logic [STAMP_W-1:0] lo;

        n      = (frames_filled_q > FRAMES) ? FRAMES : frames_filled_q;
        limit  = (capacity_q == 0) ? 1 : ((capacity_q > FRAMES) ? FRAMES : capacity_q);
        slot   = 0;
        oldest = 0;
        found  = 1'b0;
        if (time_now_q < TIME_MAX)
            time_now_q = time_now_q + 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (frame_page_q[i] == page)
            begin
                found = 1'b1;
                slot  = i;
                break;
            end
            if (frame_stamp_q[i] < frame_stamp_q[oldest])
                oldest = i;
        end
        if (!found)
        begin
            if (fault_count_q != FAULT_MAX)
                fault_count_q = fault_count_q + 1'b1;
            if (n < limit)
            begin
                slot            = n;
                frames_filled_q = n + 1;
            end
            else
                slot = oldest;
            frame_page_q[slot] = page;
        end
        frame_stamp_q[slot] = time_now_q;

        // rebase stamps before the clock runs out
        if (time_now_q >= TIME_RENORM && frames_filled_q != 0)
        begin
            lo = frame_stamp_q[0];
            for (int i = 1; i < frames_filled_q && i < FRAMES; i++)
                if (frame_stamp_q[i] < lo)
                    lo = frame_stamp_q[i];
            for (int i = 0; i < frames_filled_q && i < FRAMES; i++)
                frame_stamp_q[i] = frame_stamp_q[i] - lo;
            time_now_q = time_now_q - lo;
        end

        res.hit         = found;
        res.frame_slot  = slot[SLOT_W-1:0];
        res.fault_total = fault_count_q;
        return res;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_checked++;
            if (rsp_ch.hit)
                hits_seen++;
            if (predicted_lookups.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: hit=%0b slot=%0d faults=%0d",
                             rsp_ch.hit, rsp_ch.frame_slot, rsp_ch.fault_total);
            end
            else
            begin
                want = predicted_lookups.pop_front();
                if (rsp_ch.hit !== want.hit || rsp_ch.frame_slot !== want.frame_slot
                    || rsp_ch.fault_total !== want.fault_total)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch on result %0d: expected hit=%0b slot=%0d ",
                                  "faults=%0d, got hit=%0b slot=%0d faults=%0d"},
                                 results_checked, want.hit, want.frame_slot,
                                 want.fault_total, rsp_ch.hit, rsp_ch.frame_slot,
                                 rsp_ch.fault_total);
                end
            end
        end
        rsp_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        if (holdoff_left > 0)
            holdoff_left--;
    end

    task automatic send_page(input logic [PAGE_W-1:0] page);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= page;
        do @(posedge clk); while (!req_ch.ready);
        predicted_lookups.push_back(lookup_page(page));
        references_sent++;
    endtask

    task automatic drain_references();
        req_ch.valid <= 1'b0;
        while (predicted_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        capacity_q = value;
        capacity_writes++;
        @(posedge clk);
    endtask

    task automatic set_idle_mix(input int mix);
        case (mix)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    task automatic test_reset_capacity_extremes();
        set_idle_mix(0);
        send_page('0);
        send_page('1);
        send_page('0);
        send_page('1);
        send_page(20'h5A5A5);
        drain_references();
    endtask

    // zero acts as one frame, and lies below the frames already filled
    task automatic test_capacity_zero();
        write_capacity('0);
        send_page(20'h00001);
        send_page('1);
        send_page(20'hA5A5A);
        send_page(20'h00001);
        drain_references();
    endtask

    task automatic test_capacity_above_max();
        write_capacity('1);
        send_page(20'h80000);
        send_page(20'h40001);
        send_page(20'h20002);
        send_page(20'h10003);
        send_page(20'h08004);
        send_page(20'h04005);
        send_page(20'h80000);
        send_page(20'h00001);
        drain_references();
    endtask

    // hold the result side off long enough that the input stalls
    task automatic test_receiver_holdoff();
        set_idle_mix(0);
        holdoff_left = 300;
        for (int i = 0; i < 12; i++)
            send_page(PAGE_W'($urandom_range(0, 7)));
        drain_references();
    endtask

    task automatic test_random_references(input logic [CFG_W-1:0] cap, input int mix,
                                          input int count);
        logic [PAGE_W-1:0] pool [$];
        logic [PAGE_W-1:0] page;
        int                eff;
        int                pool_len;
        int                pick;

        write_capacity(cap);
        set_idle_mix(mix);
        eff      = (cap == 0) ? 1 : ((cap > FRAMES) ? FRAMES : cap);
        pool_len = eff + $urandom_range(0, 3);
        for (int i = 0; i < pool_len; i++)
            pool.push_back(PAGE_W'($urandom_range(0, 20'hFFFFF)));
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                page = pool[$urandom_range(pool_len - 1)];
            else if (pick < 88)
                page = pool[$urandom_range(pool_len - 1)]
                       ^ (20'd1 << $urandom_range(PAGE_W - 1));
            else if (pick < 94)
            begin
                page = PAGE_W'($urandom_range(0, 20'hFFFFF));
                pool[$urandom_range(pool_len - 1)] = page;
            end
            else
                page = PAGE_W'($urandom_range(0, 20'hFFFFF));
            send_page(page);
        end
        drain_references();
    endtask

    initial
    begin
        logic [CFG_W-1:0] caps [10];

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.page_number <= '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        holdoff_left       = 0;
        frames_filled_q    = 0;
        time_now_q         = '0;
        fault_count_q      = '0;
        capacity_q         = CFG_RESET;
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_page_q[i]  = '0;
            frame_stamp_q[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_capacity_extremes();
        test_capacity_zero();
        test_capacity_above_max();
        test_receiver_holdoff();

        caps = '{6'd4, 6'd12, 6'd16, 6'd25, 6'd31, 6'd32, 6'd63, 6'd2, 6'd0, 6'd1};
        caps[9] = CFG_W'($urandom_range(1, FRAMES));
        for (int k = 0; k < 10; k++)
            test_random_references(caps[k], k % 4, 185);

        drain_references();
        repeat (SETTLE) @(posedge clk);

        $display("Checked %0d results of %0d references (%0d hits, %0d faults)",
                 results_checked, references_sent, hits_seen, fault_count_q);
        $display("over %0d capacity writes from 0 to 63, four idle mixes and one long stall",
                 capacity_writes);
        if (errors == 0 && predicted_lookups.size() == 0)
            $display("PASS lru_page_replacement_top");
        else
            $display("FAIL lru_page_replacement_top");
        $finish;
    end

endmodule
